/* rtl/rpn_pkg.sv */
// package for the rpn expression evaluator: sizes, character codes and status codes
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int ITER_W = $clog2(VALUE_WIDTH);

  localparam int SYM_W  = 8;
  localparam int RES_W  = 32;
  localparam int LINE_W = 16;
  localparam int STAT_W = 3;
  localparam int OUT_W  = RES_W + LINE_W;

  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

endpackage

/* rtl/rpn_expression_evaluator_core.sv */
// rpn expression evaluator: character stream in, one result item per line out
//
//  channel | ports                          | item
//  --------+--------------------------------+--------------------------------------
//  in      | in_tvalid in_tready in_tdata   | one character, tlast marks end of line
//  out     | out_tvalid out_tready out_tdata| line result, status in tuser
//
// a new character is taken only in idle, after the last one is done; + and - use one add,
// * and / shift and add or subtract through the one shared adder, end of line reads the top
// the stack memory has one write port and one registered read port; the adder is shared
// synchronous active-low reset clears the stack count, line state and line counter
// the stack memory is not cleared; only entries below the count are read
// a finished result waits in the output register; an end of line stalls only there
module rpn_expression_evaluator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rpn_pkg::SYM_W-1:0]         in_tdata,   // symbol[7:0]
  input  logic                              in_tlast,   // end_of_line
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rpn_pkg::OUT_W-1:0]         out_tdata,  // result_value[31:0], line_number[47:32]
  output logic [rpn_pkg::STAT_W-1:0]        out_tuser   // status[2:0]
);

  localparam int W = rpn_pkg::VALUE_WIDTH;

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_DECODE = 14'h0002,
    S_OPCHK  = 14'h0004,
    S_RDR    = 14'h0008,
    S_RDL    = 14'h0010,
    S_ADDSUB = 14'h0020,
    S_MUL    = 14'h0040,
    S_NEGA   = 14'h0080,
    S_NEGB   = 14'h0100,
    S_DIV    = 14'h0200,
    S_NEGQ   = 14'h0400,
    S_WRITE  = 14'h0800,
    S_RDTOP  = 14'h1000,
    S_OUT    = 14'h2000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [rpn_pkg::SYM_W-1:0]     sym_r, sym_nxt;
  logic                          eol_r, eol_nxt;
  logic [rpn_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [W-1:0]                  acc_r, acc_nxt;
  logic                          pend_r, pend_nxt;
  rpn_pkg::status_t              err_r, err_nxt;
  logic [rpn_pkg::LINE_W-1:0]    line_r, line_nxt;
  logic [W-1:0]                  a_r, a_nxt;
  logic [W-1:0]                  b_r, b_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic [rpn_pkg::ITER_W-1:0]    iter_r, iter_nxt;
  logic                          negq_r, negq_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rpn_pkg::RES_W-1:0]     out_value_r, out_value_nxt;
  logic [rpn_pkg::LINE_W-1:0]    out_line_r, out_line_nxt;
  rpn_pkg::status_t              out_stat_r, out_stat_nxt;

  logic [W-1:0]                  mem [rpn_pkg::STACK_DEPTH];
  logic [W-1:0]                  mem_rd_r;
  logic                          mem_we;
  logic [rpn_pkg::IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [W-1:0]                  mem_wdata;

  logic [W-1:0]                  unit_x, unit_y;
  logic                          unit_sub;
  logic [W:0]                    unit_sum;

  logic [rpn_pkg::CNT_W-1:0]     cnt_m1, cnt_m2;
  logic                          is_digit, is_op, is_space, stack_full, load_out;
  logic [W-1:0]                  acc_x10, div_shift;
  rpn_pkg::status_t              line_stat;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_line_r, out_value_r};
  assign out_tuser  = out_stat_r;

  assign cnt_m1     = cnt_r - rpn_pkg::CNT_W'(1);
  assign cnt_m2     = cnt_r - rpn_pkg::CNT_W'(2);
  assign is_digit   = (sym_r >= rpn_pkg::CH_ZERO) && (sym_r <= rpn_pkg::CH_NINE);
  assign is_op      = (sym_r == rpn_pkg::CH_PLUS) || (sym_r == rpn_pkg::CH_MINUS) ||
                      (sym_r == rpn_pkg::CH_STAR) || (sym_r == rpn_pkg::CH_SLASH);
  assign is_space   = (sym_r == rpn_pkg::CH_SPACE);
  assign stack_full = (cnt_r >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
  assign acc_x10    = {acc_r[W-4:0], 3'b000} + {acc_r[W-2:0], 1'b0} + W'(sym_r[3:0]);
  assign div_shift  = {rem_r[W-2:0], a_r[W-1]};
  assign load_out   = !out_valid_r || out_tready;

  // shared add/subtract unit with carry out
  assign unit_sum = {1'b0, unit_x} + {1'b0, (unit_sub ? ~unit_y : unit_y)} +
                    {{W{1'b0}}, unit_sub};

  always_comb begin
    unit_x   = a_r;
    unit_y   = b_r;
    unit_sub = 1'b0;
    unique case (state_r) inside
      S_ADDSUB: begin
        unit_sub = (sym_r == rpn_pkg::CH_MINUS);
      end
      S_MUL: begin
        unit_x = rem_r;
        unit_y = a_r;
      end
      S_NEGA, S_NEGQ: begin
        unit_x   = '0;
        unit_y   = a_r;
        unit_sub = 1'b1;
      end
      S_NEGB: begin
        unit_x   = '0;
        unit_sub = 1'b1;
      end
      S_DIV: begin
        unit_x   = div_shift;
        unit_sub = 1'b1;
      end
      default: begin
        unit_x = a_r;
      end
    endcase
  end

  always_comb begin
    if (err_r != rpn_pkg::ST_OK) begin
      line_stat = err_r;
    end else if (cnt_r == '0) begin
      line_stat = rpn_pkg::ST_EMPTY;
    end else begin
      line_stat = rpn_pkg::ST_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    eol_nxt       = eol_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    line_nxt      = line_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rem_nxt       = rem_r;
    iter_nxt      = iter_r;
    negq_nxt      = negq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_line_nxt  = out_line_r;
    out_stat_nxt  = out_stat_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[rpn_pkg::IDX_W-1:0];
    mem_wdata     = acc_r;
    mem_raddr     = cnt_m1[rpn_pkg::IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sym_nxt   = in_tdata;
          eol_nxt   = in_tlast;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (err_r != rpn_pkg::ST_OK) begin
          if (eol_r) begin
            state_nxt = S_RDTOP;
          end
        end else if (!eol_r && is_digit) begin
          acc_nxt  = acc_x10;
          pend_nxt = 1'b1;
        end else if (eol_r || is_op || is_space) begin
          // flush pending number
          if (pend_r) begin
            if (stack_full) begin
              err_nxt = rpn_pkg::ST_OVERFLOW;
            end else begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + rpn_pkg::CNT_W'(1);
            end
          end
          acc_nxt  = '0;
          pend_nxt = 1'b0;
          if (eol_r) begin
            state_nxt = S_RDTOP;
          end else if (is_op) begin
            state_nxt = S_OPCHK;
          end
        end
      end
      S_OPCHK: begin
        if (err_r != rpn_pkg::ST_OK) begin
          state_nxt = S_IDLE;
        end else if (cnt_r < rpn_pkg::CNT_W'(2)) begin
          err_nxt   = rpn_pkg::ST_UNDERFLOW;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RDR;
        end
      end
      S_RDR: begin
        b_nxt     = mem_rd_r;
        mem_raddr = cnt_m2[rpn_pkg::IDX_W-1:0];
        state_nxt = S_RDL;
      end
      S_RDL: begin
        a_nxt    = mem_rd_r;
        rem_nxt  = '0;
        iter_nxt = rpn_pkg::ITER_W'(W - 1);
        negq_nxt = mem_rd_r[W-1] ^ b_r[W-1];
        if (sym_r == rpn_pkg::CH_SLASH) begin
          if (b_r == '0) begin
            err_nxt   = rpn_pkg::ST_DIVZERO;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NEGA;
          end
        end else if (sym_r == rpn_pkg::CH_STAR) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_ADDSUB;
        end
      end
      S_ADDSUB: begin
        a_nxt     = unit_sum[W-1:0];
        state_nxt = S_WRITE;
      end
      S_MUL: begin
        if (b_r[0]) begin
          rem_nxt = unit_sum[W-1:0];
        end
        a_nxt = {a_r[W-2:0], 1'b0};
        b_nxt = {1'b0, b_r[W-1:1]};
        if (iter_r == '0) begin
          a_nxt     = b_r[0] ? unit_sum[W-1:0] : rem_r;
          state_nxt = S_WRITE;
        end else begin
          iter_nxt = iter_r - rpn_pkg::ITER_W'(1);
        end
      end
      S_NEGA: begin
        if (a_r[W-1]) begin
          a_nxt = unit_sum[W-1:0];
        end
        state_nxt = S_NEGB;
      end
      S_NEGB: begin
        if (b_r[W-1]) begin
          b_nxt = unit_sum[W-1:0];
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (unit_sum[W]) begin
          rem_nxt = unit_sum[W-1:0];
          a_nxt   = {a_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift;
          a_nxt   = {a_r[W-2:0], 1'b0};
        end
        if (iter_r == '0) begin
          state_nxt = S_NEGQ;
        end else begin
          iter_nxt = iter_r - rpn_pkg::ITER_W'(1);
        end
      end
      S_NEGQ: begin
        if (negq_r) begin
          a_nxt = unit_sum[W-1:0];
        end
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[rpn_pkg::IDX_W-1:0];
        mem_wdata = a_r;
        cnt_nxt   = cnt_m1;
        state_nxt = S_IDLE;
      end
      S_RDTOP: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = line_stat;
          out_value_nxt = (line_stat == rpn_pkg::ST_OK) ?
                          rpn_pkg::RES_W'(mem_rd_r) : '0;
          out_line_nxt  = line_r;
          line_nxt      = line_r + rpn_pkg::LINE_W'(1);
          cnt_nxt       = '0;
          acc_nxt       = '0;
          pend_nxt      = 1'b0;
          err_nxt       = rpn_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      pend_r      <= 1'b0;
      err_r       <= rpn_pkg::ST_OK;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    eol_r       <= eol_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    rem_r       <= rem_nxt;
    iter_r      <= iter_nxt;
    negq_r      <= negq_nxt;
    out_value_r <= out_value_nxt;
    out_line_r  <= out_line_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack count above depth");

  a_write_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> cnt_r >= rpn_pkg::CNT_W'(2))
    else $error("operator result written with fewer than two values");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && load_out |=> cnt_r == '0 && err_r == rpn_pkg::ST_OK && out_valid_r)
    else $error("line state not cleared after result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r != rpn_pkg::ST_OK |-> out_value_r == '0)
    else $error("error result carries a value");

endmodule
